FILE: hw/rtl/bgrc_pkg.sv
package bgrc_pkg;

   // Field and register widths
   localparam int VALUE_W    = 18;
   localparam int GAIN_W     = 16;
   localparam int START_W    = 8;
   localparam int LEVELS_W   = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   // Top code of the 8-bit scale and full scale in percent
   localparam int CODE_MAX     = 255;
   localparam int PERCENT_FULL = 100;

   // Parameter defaults
   localparam int DEF_MAX_LEVELS      = 4096;
   localparam int DEF_VALUE_FRAC_BITS = 10;
   localparam int DEF_GAIN_FRAC_BITS  = 14;

   // Register reset values
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd16384;
   localparam logic [START_W-1:0]  START_RESET  = 8'd236;
   localparam logic [LEVELS_W-1:0] LEVELS_RESET = 13'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN         = 2'd0,
      CSR_START        = 2'd1,
      CSR_EFF_LEVELS   = 2'd2,
      CSR_TOTAL_LEVELS = 2'd3
   } csr_reg_type;

endpackage

FILE: hw/rtl/bgrc_div.sv
module bgrc_div #(
   parameter int NUM_W = 31,
   parameter int DEN_W = bgrc_pkg::START_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   import bgrc_pkg::*;

   localparam int STEP_BITS = 2;
   localparam int PAD_W     = NUM_W + (NUM_W % STEP_BITS);
   localparam int ROUNDS    = PAD_W / STEP_BITS;
   localparam int CNT_W     = $clog2(ROUNDS + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [PAD_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W-1:0] rem_in;
   logic [PAD_W-1:0] quo_in;
   logic [DEN_W:0]   trial;

   // Two restoring steps per cycle: shift in a dividend bit, subtract if it fits
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial  = {rem_in, quo_in[PAD_W-1]};
         quo_in = {quo_in[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROUNDS);
            rem_ff  <= '0;
            quo_ff  <= PAD_W'(numer);
            den_ff  <= denom;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[NUM_W-1:0];

endmodule

FILE: hw/rtl/blue_gain_ramp_curve.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_first_of_curve, req_level_value
// rsp     | out       | rsp_valid/rsp_stall | rsp_level_index, rsp_adjusted_value,
//         |           |                     | rsp_last_of_curve
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One item at a time, with one multiplier shared by the gain and the ramp slope.
// A scaled level passes ST_DECIDE, ST_SCALE, ST_OUT; a ramp level passes
// ST_DECIDE, ST_DIV_START, ST_DIV_WAIT (2-bit-per-cycle serial divider), ST_OUT;
// a level past the effective count, or a ramp level with a zero divisor, passes
// ST_DECIDE, ST_OUT. The next item waits for ST_IDLE, after the result is taken.
// Reset is synchronous: registers return to their defaults and the level
// counter, ramp base and final value clear.
// req_stall stays high from accept until the result is taken on rsp.
module blue_gain_ramp_curve #(
   parameter int MAX_LEVELS      = bgrc_pkg::DEF_MAX_LEVELS,
   parameter int VALUE_FRAC_BITS = bgrc_pkg::DEF_VALUE_FRAC_BITS,
   parameter int GAIN_FRAC_BITS  = bgrc_pkg::DEF_GAIN_FRAC_BITS,
   localparam int IDX_W          = $clog2(MAX_LEVELS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_first_of_curve,
   input  logic [bgrc_pkg::VALUE_W-1:0]    req_level_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [IDX_W-1:0]                rsp_level_index,
   output logic [bgrc_pkg::VALUE_W-1:0]    rsp_adjusted_value,
   output logic                            rsp_last_of_curve,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bgrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bgrc_pkg::CSR_DATA_W-1:0] csr_data
);
   import bgrc_pkg::*;

   localparam int CMP_W   = (IDX_W + 1 > LEVELS_W) ? IDX_W + 1 : LEVELS_W;
   localparam int FULL_W  = VALUE_FRAC_BITS + 7;
   localparam int DIFF_W  = (FULL_W > VALUE_W) ? FULL_W : VALUE_W;
   localparam int MUL_A_W = DIFF_W;
   localparam int MUL_B_W = (GAIN_W > IDX_W) ? GAIN_W : IDX_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int QUO_W   = DIFF_W + IDX_W + 1;
   localparam int SCL_W   = PROD_W + 1;
   localparam logic [FULL_W-1:0] FULL_VALUE = FULL_W'(PERCENT_FULL) << VALUE_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCALE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   // Configuration registers
   logic [GAIN_W-1:0]   gain_ff;
   logic [START_W-1:0]  start_ff;
   logic [LEVELS_W-1:0] eff_ff;
   logic [LEVELS_W-1:0] total_ff;

   state_type            state_ff;
   logic [IDX_W-1:0]     counter_ff;
   logic [VALUE_W-1:0]   ramp_base_ff;
   logic [VALUE_W-1:0]   final_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 rsp_valid_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_last_ff;

   logic [START_W-1:0]   rem_code;
   logic [LEVELS_W-1:0]  split;
   logic [CMP_W-1:0]     idx_x;
   logic [CMP_W-1:0]     idx_p1;
   logic [CMP_W-1:0]     split_x;
   logic [CMP_W-1:0]     k_full;
   logic [IDX_W-1:0]     k;
   logic                 in_scale;
   logic                 in_ramp;
   logic [DIFF_W-1:0]    base_x;
   logic [DIFF_W-1:0]    full_x;
   logic                 ramp_up;
   logic [DIFF_W-1:0]    diff;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [PROD_W-1:0]    product;
   logic [SCL_W-1:0]     scl_sum;
   logic [SCL_W-1:0]     scl_shift;
   logic [VALUE_W-1:0]   scaled;
   logic [QUO_W-1:0]     div_num;
   logic                 div_start;
   logic                 div_done;
   logic [QUO_W-1:0]     quo;
   logic [QUO_W:0]       up_sum;
   logic [VALUE_W-1:0]   ramp_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         start_ff <= START_RESET;
         eff_ff   <= LEVELS_RESET;
         total_ff <= LEVELS_RESET;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_GAIN:         gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_START:        start_ff <= csr_data[START_W-1:0];
            CSR_EFF_LEVELS:   eff_ff   <= csr_data[LEVELS_W-1:0];
            CSR_TOTAL_LEVELS: total_ff <= csr_data[LEVELS_W-1:0];
            default: ;
         endcase
      end
   end

   // Split point: effective count minus ramp length, at least one
   assign rem_code = START_W'(CODE_MAX) - start_ff;
   assign split    = (eff_ff > LEVELS_W'(rem_code)) ? eff_ff - LEVELS_W'(rem_code)
                                                    : LEVELS_W'(1);

   assign idx_x    = CMP_W'(idx_ff);
   assign idx_p1   = idx_x + CMP_W'(1);
   assign split_x  = CMP_W'(split);
   assign in_scale = idx_x < split_x;
   assign in_ramp  = idx_x < CMP_W'(eff_ff);
   assign k_full   = idx_p1 - split_x;
   assign k        = k_full[IDX_W-1:0];

   assign base_x  = DIFF_W'(ramp_base_ff);
   assign full_x  = DIFF_W'(FULL_VALUE);
   assign ramp_up = full_x >= base_x;
   assign diff    = ramp_up ? full_x - base_x : base_x - full_x;

   // Shared multiplier: gain on the scaled side, ramp span times step on the ramp
   assign mul_a   = in_scale ? MUL_A_W'(value_ff) : diff;
   assign mul_b   = in_scale ? MUL_B_W'(gain_ff) : MUL_B_W'(k);
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign scl_sum   = SCL_W'(prod_ff) + (SCL_W'(1) << (GAIN_FRAC_BITS - 1));
   assign scl_shift = scl_sum >> GAIN_FRAC_BITS;
   assign scaled    = (scl_shift > SCL_W'(VALUE_MAX)) ? VALUE_MAX
                                                      : scl_shift[VALUE_W-1:0];

   // Add half the divisor so the floor division rounds to nearest
   assign div_num   = {1'b0, prod_ff[QUO_W-2:0]} + QUO_W'(rem_code >> 1);
   assign div_start = (state_ff == ST_DIV_START);

   bgrc_div #(
      .NUM_W (QUO_W),
      .DEN_W (START_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (rem_code),
      .done     (div_done),
      .quotient (quo)
   );

   assign up_sum = (QUO_W + 1)'(ramp_base_ff) + (QUO_W + 1)'(quo);

   always_comb begin
      if (ramp_up) begin
         ramp_res = (up_sum > (QUO_W + 1)'(VALUE_MAX)) ? VALUE_MAX : up_sum[VALUE_W-1:0];
      end else if (quo >= QUO_W'(ramp_base_ff)) begin
         ramp_res = '0;
      end else begin
         ramp_res = ramp_base_ff - quo[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         ramp_base_ff <= '0;
         final_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  idx_ff   <= req_first_of_curve ? '0 : counter_ff;
                  value_ff <= req_level_value;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               counter_ff   <= idx_ff + IDX_W'(1);
               rsp_index_ff <= idx_ff;
               rsp_last_ff  <= (idx_p1 == CMP_W'(total_ff));
               prod_ff      <= product;
               if (in_scale) begin
                  state_ff <= ST_SCALE;
               end else if (in_ramp && rem_code != '0) begin
                  state_ff <= ST_DIV_START;
               end else if (in_ramp) begin
                  rsp_value_ff <= ramp_base_ff;
                  final_ff     <= ramp_base_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  // past the effective count: repeat the last value
                  rsp_value_ff <= final_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end
            end
            ST_SCALE: begin
               rsp_value_ff <= scaled;
               final_ff     <= scaled;
               if (idx_p1 == split_x) begin
                  ramp_base_ff <= scaled;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  rsp_value_ff <= ramp_res;
                  final_ff     <= ramp_res;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_index    = rsp_index_ff;
   assign rsp_adjusted_value = rsp_value_ff;
   assign rsp_last_of_curve  = rsp_last_ff;

endmodule

FILE: hw/rtl/bgrc_checker.sv
module bgrc_checker #(
   parameter int MAX_LEVELS = bgrc_pkg::DEF_MAX_LEVELS,
   localparam int IDX_W     = $clog2(MAX_LEVELS)
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [IDX_W-1:0]             rsp_level_index,
   input logic [bgrc_pkg::VALUE_W-1:0] rsp_adjusted_value,
   input logic                         rsp_last_of_curve
);
   import bgrc_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level_index)
         && $stable(rsp_adjusted_value) && $stable(rsp_last_of_curve))
      else $error("stalled item changed on rsp");

   // No new item while a result waits
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req open while rsp holds an item");

   // An accepted item closes req and cannot answer in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("req still open or rsp too early after accept");

   // Taking the result reopens req at once
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid && !req_stall)
      else $error("req not reopened after rsp item taken");

endmodule

bind blue_gain_ramp_curve bgrc_checker #(
   .MAX_LEVELS (MAX_LEVELS)
) u_bgrc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_level_index    (rsp_level_index),
   .rsp_adjusted_value (rsp_adjusted_value),
   .rsp_last_of_curve  (rsp_last_of_curve)
);

FILE: tb/blue_gain_ramp_curve_test.sv
`timescale 1ns / 100ps

module blue_gain_ramp_curve_test;
   import bgrc_pkg::*;

   localparam int IDX_W = $clog2(DEF_MAX_LEVELS);
   localparam longint unsigned FULL_SCALE = longint'(PERCENT_FULL) << DEF_VALUE_FRAC_BITS;
   localparam longint unsigned GAIN_HALF = longint'(1) << (DEF_GAIN_FRAC_BITS - 1);
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic               first;
      logic [VALUE_W-1:0] val;
   } level_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] val;
      logic               last_flag;
   } level_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_first_of_curve = 1'b0;
   logic [VALUE_W-1:0]    req_level_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [IDX_W-1:0]      rsp_level_index;
   logic [VALUE_W-1:0]    rsp_adjusted_value;
   logic                  rsp_last_of_curve;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers and curve state
   logic [GAIN_W-1:0]   gain_q;
   logic [START_W-1:0]  start_q;
   logic [LEVELS_W-1:0] eff_q;
   logic [LEVELS_W-1:0] total_q;
   logic [IDX_W-1:0]    next_index;
   logic [VALUE_W-1:0]  ramp_base_q;
   logic [VALUE_W-1:0]  hold_value_q;

   level_item_type   pending_levels[$];
   level_result_type expected_levels[$];
   level_item_type   drive_item;
   level_result_type want_level;

   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned rsp_count = 0;
   int unsigned errors = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   logic        req_took = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   blue_gain_ramp_curve dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_of_curve (req_first_of_curve),
      .req_level_value    (req_level_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level_index    (rsp_level_index),
      .rsp_adjusted_value (rsp_adjusted_value),
      .rsp_last_of_curve  (rsp_last_of_curve),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [VALUE_W-1:0] clip_value(longint unsigned x);
      return (x > VALUE_MAX) ? VALUE_MAX : x[VALUE_W-1:0];
   endfunction

   // ramp from the base toward full scale; the slope may point down
   function automatic logic [VALUE_W-1:0] ramp_level(longint unsigned k, longint unsigned span);
      longint unsigned base;
      longint unsigned q;
      base = ramp_base_q;
      if (span == 0)
         return ramp_base_q;
      if (FULL_SCALE >= base) begin
         q = ((FULL_SCALE - base) * k + span / 2) / span;
         return clip_value(base + q);
      end
      q = ((base - FULL_SCALE) * k + span / 2) / span;
      return (q >= base) ? '0 : clip_value(base - q);
   endfunction

   function automatic level_result_type predict_level(logic first, logic [VALUE_W-1:0] v);
      int unsigned      idx;
      int unsigned      span;
      int unsigned      split;
      int               split_s;
      longint unsigned  prod;
      logic [VALUE_W-1:0] res;
      level_result_type r;
      idx = first ? 0 : next_index;
      span = CODE_MAX - start_q;
      split_s = int'(eff_q) - int'(span);
      split = (split_s < 1) ? 1 : $unsigned(split_s);
      if (idx < split) begin
         prod = longint'(v) * longint'(gain_q) + GAIN_HALF;
         res = clip_value(prod >> DEF_GAIN_FRAC_BITS);
         if (idx + 1 == split)
            ramp_base_q = res;
         hold_value_q = res;
      end else if (idx < eff_q) begin
         res = ramp_level(idx - split + 1, span);
         hold_value_q = res;
      end else begin
         res = hold_value_q;
      end
      next_index = IDX_W'(idx + 1);
      r.idx = IDX_W'(idx);
      r.val = res;
      r.last_flag = (idx + 1 == total_q);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return VALUE_MAX;
         2, 3: return VALUE_W'($urandom_range(FULL_SCALE, VALUE_MAX));
         default: return VALUE_W'($urandom_range(0, VALUE_MAX));
      endcase
   endfunction

   task automatic queue_level(logic first, logic [VALUE_W-1:0] v);
      level_item_type it;
      it.first = first;
      it.val = v;
      pending_levels.push_back(it);
      items_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (items_accepted != items_queued || expected_levels.size() != 0);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic change_setting(logic [GAIN_W-1:0] g, logic [START_W-1:0] s,
                                 logic [LEVELS_W-1:0] e, logic [LEVELS_W-1:0] t);
      wait_drained();
      write_reg(CSR_GAIN, CSR_DATA_W'(g));
      write_reg(CSR_START, CSR_DATA_W'(s));
      write_reg(CSR_EFF_LEVELS, CSR_DATA_W'(e));
      write_reg(CSR_TOTAL_LEVELS, CSR_DATA_W'(t));
      @(posedge clock);
   endtask

   task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // mostly whole curves from a first mark, some cut short or overlong,
   // an occasional stray mark mid-curve
   task automatic queue_random_curves(int unsigned budget, int unsigned curve_len);
      int unsigned made;
      int unsigned len;
      int unsigned n;
      made = 0;
      while (made < budget) begin
         len = (curve_len <= 160) ? curve_len : $urandom_range(20, 160);
         if ($urandom_range(0, 6) == 0)
            len = $urandom_range(1, len + 4);
         for (n = 0; n < len; n++) begin
            if (n == 0)
               queue_level(made != 0 || $urandom_range(0, 2) != 0, pick_value());
            else
               queue_level($urandom_range(0, 49) == 0, pick_value());
         end
         made += len;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_levels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_item = pending_levels.pop_front();
            req_valid <= 1'b1;
            req_first_of_curve <= drive_item.first;
            req_level_value <= drive_item.val;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // one long hold-off early on so the block backs up into its input
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= 60) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      req_took = 1'b0;
      if (reset) begin
         gain_q = GAIN_RESET;
         start_q = START_RESET;
         eff_q = LEVELS_RESET;
         total_q = LEVELS_RESET;
         next_index = '0;
         ramp_base_q = '0;
         hold_value_q = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_levels.size() == 0) begin
               $display("%0t unexpected level result: index %0d value %0d", $time,
                        rsp_level_index, rsp_adjusted_value);
               errors++;
            end else begin
               want_level = expected_levels.pop_front();
               check_field("level_index", 32'(want_level.idx), 32'(rsp_level_index));
               check_field("adjusted_value", 32'(want_level.val), 32'(rsp_adjusted_value));
               check_field("last_of_curve", 32'(want_level.last_flag),
                           32'(rsp_last_of_curve));
            end
         end
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            items_accepted++;
            expected_levels.push_back(predict_level(req_first_of_curve, req_level_value));
         end
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               CSR_GAIN:         gain_q = csr_data[GAIN_W-1:0];
               CSR_START:        start_q = csr_data[START_W-1:0];
               CSR_EFF_LEVELS:   eff_q = csr_data[LEVELS_W-1:0];
               CSR_TOTAL_LEVELS: total_q = csr_data[LEVELS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int unsigned         p;
      logic [GAIN_W-1:0]   g;
      logic [START_W-1:0]  s;
      logic [LEVELS_W-1:0] e;
      logic [LEVELS_W-1:0] t;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idle(19, 53);
      @(posedge clock);

      // registers at their reset values
      queue_level(1'b1, VALUE_MAX);
      queue_level(1'b0, '0);
      queue_level(1'b0, 18'd1);
      queue_level(1'b1, 18'h2AAAA);
      queue_level(1'b0, 18'h15555);

      // max gain saturates; base above full scale ramps down, then repeats
      change_setting('1, 8'd250, 13'd8, 13'd10);
      queue_level(1'b1, VALUE_MAX);
      queue_level(1'b0, '0);
      queue_level(1'b0, VALUE_MAX);
      repeat (9) queue_level(1'b0, pick_value());

      // split clamped to one, ramp divisor still from the start code
      change_setting(16'd8192, 8'd200, 13'd10, 13'd6);
      queue_level(1'b1, VALUE_MAX);
      repeat (5) queue_level(1'b0, pick_value());

      // empty ramp region, zero gain
      change_setting('0, 8'd254, 13'd1, 13'd1);
      queue_level(1'b1, VALUE_MAX);
      queue_level(1'b0, pick_value());
      queue_level(1'b0, pick_value());

      for (p = 0; p < 12; p++) begin
         case ($urandom_range(0, 3))
            0: g = '0;
            1: g = '1;
            default: g = GAIN_W'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 4))
            0: s = '0;
            1: s = 8'd254;
            2, 3: s = START_W'($urandom_range(180, 254));
            default: s = START_W'($urandom_range(0, 254));
         endcase
         case ($urandom_range(0, 7))
            0: e = 13'd1;
            1: e = 13'd4096;
            default: e = LEVELS_W'($urandom_range(2, 64));
         endcase
         case ($urandom_range(0, 5))
            0: t = 13'd1;
            1: t = 13'd4096;
            2, 3: t = LEVELS_W'($urandom_range(1, 72));
            default: t = (e > 4088) ? 13'd4096 : LEVELS_W'(e + $urandom_range(0, 8));
         endcase
         change_setting(g, s, e, t);
         if (p == 4)
            set_idle(53, 19);
         else if (p == 8)
            set_idle(0, 0);
         queue_random_curves(60, t);
      end

      // ramp over the top 255 levels to full scale, then repeat the end value
      change_setting(GAIN_W'($urandom_range(0, 65535)), '0, 13'd300, 13'd300);
      queue_level(1'b1, pick_value());
      repeat (309) queue_level(1'b0, pick_value());

      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
